FILE: rtl/core/qpt_pkg.sv
`timescale 1ns / 1ps
package qpt_pkg;

   localparam int LANE_W = 16;
   localparam int QUAT_W = 17;
   localparam int MID_W  = 44;
   localparam int OUT_W  = 24;
   localparam int PROD_W = 61;
   localparam int ACC_W  = 64;
   localparam int CFG_W  = 64;
   localparam int IDX_W  = 3;

   localparam logic [IDX_W-1:0] REG_LOCAL_SCALE = 3'd0;
   localparam logic [IDX_W-1:0] REG_LOCAL_ROT   = 3'd1;
   localparam logic [IDX_W-1:0] REG_LOCAL_OFF   = 3'd2;
   localparam logic [IDX_W-1:0] REG_OUTER_SCALE = 3'd3;
   localparam logic [IDX_W-1:0] REG_OUTER_ROT   = 3'd4;
   localparam logic [IDX_W-1:0] REG_OUTER_OFF   = 3'd5;

   localparam logic [47:0] LOCAL_SCALE_RST = 48'h0100_0100_0100;
   localparam logic [63:0] ROT_RST         = 64'h4000_0000_0000_0000;
   localparam logic [63:0] OUTER_SCALE_RST = 64'h0000_0100_0100_0100;

   typedef logic signed [MID_W-1:0]  mid_type;
   typedef logic signed [QUAT_W-1:0] quat_type;

   typedef struct packed {
      logic                     req_type;
      logic signed [LANE_W-1:0] in_x;
      logic signed [LANE_W-1:0] in_y;
      logic signed [LANE_W-1:0] in_z;
   } qpt_req_type;

   typedef struct packed {
      logic signed [OUT_W-1:0] res_w;
      logic signed [OUT_W-1:0] res_x;
      logic signed [OUT_W-1:0] res_y;
      logic signed [OUT_W-1:0] res_z;
   } qpt_rsp_type;

   function automatic mid_type sat_mid(input logic signed [ACC_W-1:0] v);
      logic signed [ACC_W-1:0] hi;
      logic signed [ACC_W-1:0] lo;
      hi = (ACC_W'(1) <<< (MID_W-1)) - ACC_W'(1);
      lo = -(ACC_W'(1) <<< (MID_W-1));
      if (v > hi) return hi[MID_W-1:0];
      else if (v < lo) return lo[MID_W-1:0];
      else return v[MID_W-1:0];
   endfunction

   function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [ACC_W-1:0] v);
      logic signed [ACC_W-1:0] hi;
      logic signed [ACC_W-1:0] lo;
      hi = (ACC_W'(1) <<< (OUT_W-1)) - ACC_W'(1);
      lo = -(ACC_W'(1) <<< (OUT_W-1));
      if (v > hi) return hi[OUT_W-1:0];
      else if (v < lo) return lo[OUT_W-1:0];
      else return v[OUT_W-1:0];
   endfunction

   function automatic logic signed [LANE_W-1:0] lane(input logic [CFG_W-1:0] word,
                                                     input int idx);
      return word[CFG_W-1-LANE_W*idx -: LANE_W];
   endfunction

endpackage

FILE: rtl/core/quaternion_point_transform.sv
`timescale 1ns / 1ps
// Scale, rotate, translate (type 1 only) one 3D vector to a Q16.8 quaternion.
// req_*: one beat per vector (type, x, y, z in Q8.8), valid/ready.
// rsp_*: one beat per result (w, x, y, z), valid/ready, in request order.
// csr_*: write-only registers, index as listed in qpt_pkg; write only
// while no beat is in flight.
// One beat per cycle is sustained while the output is not stalled; the rate
// is set by a single enable that advances the whole 14-stage pipeline, with
// four two-stage Hamilton product units (16 multipliers each) in the middle.
// When rsp_ready is low with a result waiting, the whole pipeline holds and
// req_ready drops in the same cycle; nothing is lost or repeated.
// Reset (synchronous, active high) empties the pipeline and returns the
// registers to identity scale and rotation and zero offsets.
module quaternion_point_transform (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  qpt_pkg::qpt_req_type              req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output qpt_pkg::qpt_rsp_type              rsp_data,
   input  logic                              csr_we,
   input  logic [qpt_pkg::IDX_W-1:0]         csr_index,
   input  logic [qpt_pkg::CFG_W-1:0]         csr_wdata
);
   import qpt_pkg::*;

   localparam int NSTAGE = 14;

   logic [47:0]      lscale_ff;
   logic [CFG_W-1:0] lrot_ff, loff_ff, oscale_ff, orot_ff, ooff_ff;
   logic [NSTAGE-1:0] vld_ff, vld_in;
   logic [NSTAGE-1:0] typ_ff, typ_in;
   logic              en;

   mid_type  v1_ff [4];
   mid_type  t3 [4], u5 [4], b10 [4], c12 [4];
   mid_type  a6_ff [4];
   logic signed [ACC_W-1:0] pr7_ff [4];
   mid_type  b8_ff [4];
   mid_type  d13_ff [4];
   logic signed [OUT_W-1:0] o14_ff [4];
   quat_type lq [4], lqc [4], oq [4], oqc [4];

   always_ff @(posedge clock) begin
      if (reset) begin
         lscale_ff <= LOCAL_SCALE_RST;
         lrot_ff   <= ROT_RST;
         loff_ff   <= '0;
         oscale_ff <= OUTER_SCALE_RST;
         orot_ff   <= ROT_RST;
         ooff_ff   <= '0;
      end else if (csr_we) begin
         case (csr_index)
            REG_LOCAL_SCALE: lscale_ff <= csr_wdata[47:0];
            REG_LOCAL_ROT:   lrot_ff   <= csr_wdata;
            REG_LOCAL_OFF:   loff_ff   <= csr_wdata;
            REG_OUTER_SCALE: oscale_ff <= csr_wdata;
            REG_OUTER_ROT:   orot_ff   <= csr_wdata;
            REG_OUTER_OFF:   ooff_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign en        = !vld_ff[NSTAGE-1] || rsp_ready;
   assign req_ready = en;

   always_comb begin
      vld_in = {vld_ff[NSTAGE-2:0], req_valid};
      typ_in = {typ_ff[NSTAGE-2:0], req_data.req_type};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) typ_ff <= typ_in;
   end

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         lq[i] = QUAT_W'(lane(lrot_ff, i));
         oq[i] = QUAT_W'(lane(orot_ff, i));
         lqc[i] = (i == 0) ? lq[i] : -lq[i];
         oqc[i] = (i == 0) ? oq[i] : -oq[i];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         v1_ff[0] <= '0;
         v1_ff[1] <= MID_W'(req_data.in_x * $signed(lscale_ff[47:32]));
         v1_ff[2] <= MID_W'(req_data.in_y * $signed(lscale_ff[31:16]));
         v1_ff[3] <= MID_W'(req_data.in_z * $signed(lscale_ff[15:0]));
      end
   end

   qpt_hamilton u_lrot_a (.clock(clock), .en(en), .swap(1'b0), .q(lq),  .w(v1_ff), .r(t3));
   qpt_hamilton u_lrot_b (.clock(clock), .en(en), .swap(1'b1), .q(lqc), .w(t3),    .r(u5));

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 4; i++) begin
            a6_ff[i] <= typ_ff[4]
               ? sat_mid(ACC_W'(u5[i]) + (ACC_W'(lane(loff_ff, i)) <<< 8)) : u5[i];
            pr7_ff[i] <= ACC_W'(a6_ff[i]) * ACC_W'(lane(oscale_ff, i));
            b8_ff[i]  <= sat_mid((pr7_ff[i] + ACC_W'(128)) >>> 8);
         end
      end
   end

   qpt_hamilton u_orot_a (.clock(clock), .en(en), .swap(1'b0), .q(oq),  .w(b8_ff), .r(b10));
   qpt_hamilton u_orot_b (.clock(clock), .en(en), .swap(1'b1), .q(oqc), .w(b10),   .r(c12));

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 4; i++) begin
            d13_ff[i] <= typ_ff[11]
               ? sat_mid(ACC_W'(c12[i]) + (ACC_W'(lane(ooff_ff, i)) <<< 8)) : c12[i];
            o14_ff[i] <= sat_out((ACC_W'(d13_ff[i]) + ACC_W'(128)) >>> 8);
         end
      end
   end

   assign rsp_valid      = vld_ff[NSTAGE-1];
   assign rsp_data.res_w = o14_ff[0];
   assign rsp_data.res_x = o14_ff[1];
   assign rsp_data.res_y = o14_ff[2];
   assign rsp_data.res_z = o14_ff[3];

`ifndef ASSERT_OFF
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result beat changed while stalled");
   a_ready: assert property (@(posedge clock) disable iff (reset)
      req_ready == (!rsp_valid || rsp_ready))
      else $error("req_ready out of step with output stall");
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid && vld_ff == '0)
      else $error("pipeline not empty after reset");
   a_flow: assert property (@(posedge clock) disable iff (reset)
      en && vld_ff[NSTAGE-2] |=> rsp_valid)
      else $error("beat lost at last stage");
`endif

endmodule

FILE: rtl/core/qpt_hamilton.sv
`timescale 1ns / 1ps
module qpt_hamilton (
   input  logic              clock,
   input  logic              en,
   input  logic              swap,
   input  qpt_pkg::quat_type q [4],
   input  qpt_pkg::mid_type  w [4],
   output qpt_pkg::mid_type  r [4]
);
   import qpt_pkg::*;

   logic signed [PROD_W-1:0] m_ff [4][4];
   logic signed [PROD_W-1:0] p    [4][4];
   logic signed [ACC_W-1:0]  s    [4];
   mid_type                  r_ff [4];

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 4; i++)
            for (int j = 0; j < 4; j++)
               m_ff[i][j] <= PROD_W'(q[i]) * PROD_W'(w[j]);
      end
   end

   // p[l][r]: left lane l times right lane r
   always_comb begin
      for (int i = 0; i < 4; i++)
         for (int j = 0; j < 4; j++)
            p[i][j] = swap ? m_ff[j][i] : m_ff[i][j];
      s[0] = ACC_W'(p[0][0]) - ACC_W'(p[1][1]) - ACC_W'(p[2][2]) - ACC_W'(p[3][3]);
      s[1] = ACC_W'(p[0][1]) + ACC_W'(p[1][0]) + ACC_W'(p[2][3]) - ACC_W'(p[3][2]);
      s[2] = ACC_W'(p[0][2]) - ACC_W'(p[1][3]) + ACC_W'(p[2][0]) + ACC_W'(p[3][1]);
      s[3] = ACC_W'(p[0][3]) + ACC_W'(p[1][2]) - ACC_W'(p[2][1]) + ACC_W'(p[3][0]);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 4; k++)
            r_ff[k] <= sat_mid((s[k] + ACC_W'(1 <<< 13)) >>> 14);
      end
   end

   assign r = r_ff;

endmodule
